// ===== src/fhm_pkg.sv =====
package fhm_pkg;

    // default sizing
    localparam int DEF_MAX_WAITERS    = 16;
    localparam int DEF_THREAD_ID_BITS = 8;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOCK   = 2'd0,
        REQ_TRY    = 2'd1,
        REQ_UNLOCK = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_BUSY       = 3'd2,
        ST_FREED      = 3'd3,
        ST_HANDED     = 3'd4,
        ST_UNLOCK_ERR = 3'd5,
        ST_FULL       = 3'd6
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== src/fhm_ram.sv =====
module fhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fifo_handoff_mutex.sv =====
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------
// request  | in        | start high while busy low  | i_req_type, i_thread_id
// result   | out       | o_done, one cycle, no stall| o_status, o_owner_valid, o_owner_id,
//          |           |                            | o_wake_valid, o_woken_id,
//          |           |                            | o_waiter_count
//
// each request is taken at the transfer edge, which also launches the read of
// the queue head in the waiter ram; the edge that ends the update cycle
// updates owner, queue pointers and the ram, and the result shows after it
// busy is high only during the update cycle, so a new request is taken while
// the previous result is on the output ports
// synchronous active-low reset frees the mutex and empties the queue; the
// waiter ram itself is never cleared, only written entries are read
// the receiver cannot stall, every result is shown for exactly one cycle
module fifo_handoff_mutex #(
    parameter int MAX_WAITERS    = fhm_pkg::DEF_MAX_WAITERS,
    parameter int THREAD_ID_BITS = fhm_pkg::DEF_THREAD_ID_BITS,
    localparam int CNT_W = $clog2(MAX_WAITERS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fhm_pkg::REQ_W-1:0]    i_req_type,
    input  logic [THREAD_ID_BITS-1:0]    i_thread_id,
    output logic                         o_done,
    output logic [fhm_pkg::STATUS_W-1:0] o_status,
    output logic                         o_owner_valid,
    output logic [THREAD_ID_BITS-1:0]    o_owner_id,
    output logic                         o_wake_valid,
    output logic [THREAD_ID_BITS-1:0]    o_woken_id,
    output logic [CNT_W-1:0]             o_waiter_count
);
    import fhm_pkg::*;

    localparam int ADDR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

    // sequencer
    t_state r_state, n_state;

    // captured request
    logic [REQ_W-1:0]          r_req;
    logic [THREAD_ID_BITS-1:0] r_tid;

    // mutex state
    logic                      r_held, n_held;
    logic [THREAD_ID_BITS-1:0] r_holder, n_holder;
    logic [ADDR_W-1:0]         r_head, n_head;
    logic [ADDR_W-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]          r_count, n_count;

    // result registers
    logic                      r_done;
    t_status                   r_status, n_status;
    logic                      r_owner_valid;
    logic [THREAD_ID_BITS-1:0] r_owner_id;
    logic                      r_wake_valid, n_wake;
    logic [THREAD_ID_BITS-1:0] r_woken_id, n_woken;

    // waiter ram
    logic                      ram_we;
    logic [THREAD_ID_BITS-1:0] ram_rdata;

    logic accept;
    logic [ADDR_W-1:0] head_inc, tail_inc;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    // pointers wrap at the queue depth
    assign head_inc = (r_head == ADDR_W'(MAX_WAITERS - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == ADDR_W'(MAX_WAITERS - 1)) ? '0 : r_tail + 1'b1;

    // head entry is read every cycle; it is valid in the update cycle since
    // nothing writes the ram between the transfer edge and that read
    fhm_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (MAX_WAITERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_tid),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // request decode and queue update
    always_comb begin
        n_held   = r_held;
        n_holder = r_holder;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_BUSY;
        n_wake   = 1'b0;
        n_woken  = '0;
        ram_we   = 1'b0;
        if (r_state == S_EXEC) begin
            unique case (r_req)
                REQ_LOCK: begin
                    if (!r_held) begin
                        n_held   = 1'b1;
                        n_holder = r_tid;
                        n_status = ST_ACQUIRED;
                    end else if (r_count == CNT_W'(MAX_WAITERS)) begin
                        n_status = ST_FULL;
                    end else begin
                        // append the requester as a blocked waiter
                        ram_we   = 1'b1;
                        n_tail   = tail_inc;
                        n_count  = r_count + 1'b1;
                        n_status = ST_QUEUED;
                    end
                end
                REQ_TRY: begin
                    if (!r_held) begin
                        n_held   = 1'b1;
                        n_holder = r_tid;
                        n_status = ST_ACQUIRED;
                    end
                end
                REQ_UNLOCK: begin
                    if (!r_held) begin
                        n_status = ST_UNLOCK_ERR;
                    end else if (r_count != '0) begin
                        // hand ownership straight to the oldest waiter
                        n_woken  = ram_rdata;
                        n_holder = ram_rdata;
                        n_wake   = 1'b1;
                        n_head   = head_inc;
                        n_count  = r_count - 1'b1;
                        n_status = ST_HANDED;
                    end else begin
                        n_held   = 1'b0;
                        n_holder = '0;
                        n_status = ST_FREED;
                    end
                end
                default: begin
                    // undefined request code, reported busy and ignored
                    n_status = ST_BUSY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= 1'b0;
            r_holder <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_holder <= n_holder;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_done   <= (r_state == S_EXEC);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_tid <= i_thread_id;
        end
        if (r_state == S_EXEC) begin
            r_status      <= n_status;
            r_owner_valid <= n_held;
            r_owner_id    <= n_held ? n_holder : '0;
            r_wake_valid  <= n_wake;
            r_woken_id    <= n_woken;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_owner_valid  = r_owner_valid;
    assign o_owner_id     = r_owner_id;
    assign o_wake_valid   = r_wake_valid;
    assign o_woken_id     = r_woken_id;
    assign o_waiter_count = r_count;

endmodule

// ===== src/fhm_checker.sv =====
module fhm_checker #(
    parameter int MAX_WAITERS    = fhm_pkg::DEF_MAX_WAITERS,
    parameter int THREAD_ID_BITS = fhm_pkg::DEF_THREAD_ID_BITS,
    localparam int CNT_W = $clog2(MAX_WAITERS + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [fhm_pkg::STATUS_W-1:0] o_status,
    input logic                         o_owner_valid,
    input logic [THREAD_ID_BITS-1:0]    o_owner_id,
    input logic                         o_wake_valid,
    input logic [THREAD_ID_BITS-1:0]    o_woken_id,
    input logic [CNT_W-1:0]             o_waiter_count
);
    import fhm_pkg::*;

    // every transfer is followed by the busy update cycle and then by its result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_done)
        else $error("request transfer without result");

    // a result is only shown while the block is ready again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // a handover makes the woken thread the owner
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_wake_valid) |->
            (o_owner_valid && o_owner_id == o_woken_id && o_status == ST_HANDED))
        else $error("handover does not pass ownership");

    // a free mutex reports owner zero and no waiters
    a_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_owner_valid) |-> (o_owner_id == '0 && o_waiter_count == '0))
        else $error("free mutex with owner or waiters");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_waiter_count <= CNT_W'(MAX_WAITERS)))
        else $error("waiter count beyond queue depth");

endmodule

bind fifo_handoff_mutex fhm_checker #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
) u_fhm_checker (.*);

// ===== sim/tb_fifo_handoff_mutex.sv =====
module tb_fifo_handoff_mutex;
    import fhm_pkg::*;

    // sizing follows the block defaults
    localparam int MAX_WAITERS    = DEF_MAX_WAITERS;
    localparam int ID_W           = DEF_THREAD_ID_BITS;
    localparam int CNT_W          = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W          = $clog2(MAX_WAITERS);
    // quiet cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 500;
    // margin of quiet cycles after the last result is checked
    localparam int DRAIN_CYCLES   = 6;
    localparam int REPORT_LIMIT   = 10;

    // request code with no meaning, the block must ignore it
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    // one result as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                owner_valid;
        logic [ID_W-1:0]     owner_id;
        logic                wake_valid;
        logic [ID_W-1:0]     woken_id;
        logic [CNT_W-1:0]    waiter_count;
    } t_mutex_result;

    // clock, reset and block ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type = '0;
    logic [ID_W-1:0]     i_thread_id = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic                o_owner_valid;
    logic [ID_W-1:0]     o_owner_id;
    logic                o_wake_valid;
    logic [ID_W-1:0]     o_woken_id;
    logic [CNT_W-1:0]    o_waiter_count;

    // shadow copy of the mutex, updated on every accepted request
    logic                lock_held;
    logic [ID_W-1:0]     lock_owner;
    logic [ID_W-1:0]     waiter_ring [MAX_WAITERS];
    logic [IDX_W-1:0]    ring_head;
    logic [IDX_W-1:0]    ring_tail;
    logic [CNT_W-1:0]    waiters_now;

    // predicted results in request order
    t_mutex_result       pending_results [$];
    int                  fail_count = 0;
    int                  quiet_cycles;

    always #4 i_clk = ~i_clk;

    fifo_handoff_mutex dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_thread_id    (i_thread_id),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_owner_valid  (o_owner_valid),
        .o_owner_id     (o_owner_id),
        .o_wake_valid   (o_wake_valid),
        .o_woken_id     (o_woken_id),
        .o_waiter_count (o_waiter_count)
    );

    // apply one request to the shadow mutex and return what the block must report
    function automatic t_mutex_result apply_request(input logic [REQ_W-1:0] code,
                                                    input logic [ID_W-1:0] tid);
        t_mutex_result res;
        res        = '0;
        res.status = ST_BUSY;
        case (code)
            REQ_LOCK: begin
                if (!lock_held) begin
                    lock_held  = 1'b1;
                    lock_owner = tid;
                    res.status = ST_ACQUIRED;
                end else if (waiters_now >= MAX_WAITERS) begin
                    // queue full, requester dropped
                    res.status = ST_FULL;
                end else begin
                    // owner relocking lands here too and waits behind itself
                    waiter_ring[ring_tail] = tid;
                    ring_tail              = ring_tail + 1'b1;
                    waiters_now            = waiters_now + 1'b1;
                    res.status             = ST_QUEUED;
                end
            end
            REQ_TRY: begin
                if (!lock_held) begin
                    lock_held  = 1'b1;
                    lock_owner = tid;
                    res.status = ST_ACQUIRED;
                end
            end
            REQ_UNLOCK: begin
                if (!lock_held) begin
                    res.status = ST_UNLOCK_ERR;
                end else if (waiters_now != 0) begin
                    // direct handoff to the oldest waiter
                    res.wake_valid = 1'b1;
                    res.woken_id   = waiter_ring[ring_head];
                    lock_owner     = waiter_ring[ring_head];
                    ring_head      = ring_head + 1'b1;
                    waiters_now    = waiters_now - 1'b1;
                    res.status     = ST_HANDED;
                end else begin
                    lock_held  = 1'b0;
                    lock_owner = '0;
                    res.status = ST_FREED;
                end
            end
            default: ;
        endcase
        res.owner_valid  = lock_held;
        res.owner_id     = lock_held ? lock_owner : '0;
        res.waiter_count = waiters_now;
        return res;
    endfunction

    // one request transfer; returns at the edge that accepts it
    task automatic send_request(input logic [REQ_W-1:0] code, input logic [ID_W-1:0] tid);
        start       <= 1'b1;
        i_req_type  <= code;
        i_thread_id <= tid;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_request(code, tid));
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // occasional idle gap of random length before a request
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 7) == 0)
            idle_sender($urandom_range(1, 15));
    endtask

    // pick a request with the given share of lock-type requests, a little noise
    function automatic logic [REQ_W-1:0] pick_request(input int lock_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return REQ_UNDEF;
        if (roll < 2 + lock_pct)
            return ($urandom_range(0, 3) == 0) ? REQ_TRY : REQ_LOCK;
        return REQ_UNLOCK;
    endfunction

    // extremes of the ids, every request code, the unlock error path and owner relock
    task automatic test_directed_cases();
        send_request(REQ_UNLOCK, 8'h00);   // unlock while free
        send_request(REQ_UNDEF,  8'hFF);   // meaningless code while free
        send_request(REQ_TRY,    8'h00);   // trylock takes free mutex
        send_request(REQ_TRY,    8'hFF);   // trylock refused while held
        send_request(REQ_UNDEF,  8'h3C);   // meaningless code while held
        send_request(REQ_LOCK,   8'hFF);
        send_request(REQ_LOCK,   8'h5A);
        send_request(REQ_UNLOCK, 8'h00);   // handoff to first waiter
        send_request(REQ_UNLOCK, 8'h11);   // handoff by a non-owner
        send_request(REQ_UNLOCK, 8'h5A);   // release to free
        send_request(REQ_LOCK,   8'hA5);
        send_request(REQ_LOCK,   8'hA5);   // owner relocks, waits behind itself
        send_request(REQ_UNLOCK, 8'hA5);
        send_request(REQ_UNLOCK, 8'hA5);
        send_request(REQ_UNLOCK, 8'hA5);   // unlock error again after release
        send_request(REQ_LOCK,   8'h80);
        send_request(REQ_UNLOCK, 8'h7F);
    endtask

    // fill the queue past full, poke with locks and trylocks, then drain to free
    task automatic test_fill_and_overflow(input int rounds);
        int extra;
        repeat (rounds) begin
            extra = $urandom_range(1, 4);
            send_request(REQ_LOCK, ID_W'($urandom));
            while (waiters_now < MAX_WAITERS) begin
                maybe_idle(1'b1);
                send_request(REQ_LOCK, ID_W'($urandom));
            end
            repeat (extra) begin
                maybe_idle(1'b1);
                send_request(($urandom_range(0, 1) == 0) ? REQ_LOCK : REQ_TRY,
                             ID_W'($urandom));
            end
            while (lock_held) begin
                maybe_idle(1'b1);
                send_request(REQ_UNLOCK, ID_W'($urandom));
            end
            send_request(REQ_UNLOCK, ID_W'($urandom));
        end
    endtask

    // segments of random length, each leaning toward filling, draining or balance
    task automatic test_random_traffic(input int total, input bit with_idle);
        int sent;
        int seg_len;
        int lock_pct;
        bit seg_idle;
        sent = 0;
        while (sent < total) begin
            seg_len  = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       lock_pct = 85;
                1:       lock_pct = 49;
                default: lock_pct = 20;
            endcase
            // some segments run with no gaps at all
            seg_idle = with_idle && ($urandom_range(0, 3) != 0);
            repeat (seg_len) begin
                maybe_idle(seg_idle);
                send_request(pick_request(lock_pct), ID_W'($urandom));
                sent++;
            end
        end
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_mutex_result got;
        t_mutex_result want;
        if (i_rst_n && o_done) begin
            got = {o_status, o_owner_valid, o_owner_id, o_wake_valid, o_woken_id,
                   o_waiter_count};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result with no request pending: status %0d owner %0d/%0h",
                             got.status, got.owner_valid, got.owner_id);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"mismatch: exp st %0d own %0d/%0h wake %0d/%0h cnt %0d",
                                  " | got st %0d own %0d/%0h wake %0d/%0h cnt %0d"},
                                 want.status, want.owner_valid, want.owner_id,
                                 want.wake_valid, want.woken_id, want.waiter_count,
                                 got.status, got.owner_valid, got.owner_id,
                                 got.wake_valid, got.woken_id, got.waiter_count);
                end
            end
        end
    end

    // watchdog: any transfer in or result out counts as progress
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        // shadow state matches the block after reset
        lock_held   = 1'b0;
        lock_owner  = '0;
        ring_head   = '0;
        ring_tail   = '0;
        waiters_now = '0;
        foreach (waiter_ring[i]) waiter_ring[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_and_overflow(2);
        test_random_traffic(1450, 1'b1);
        // last stretch back to back, no gaps
        test_random_traffic(350, 1'b0);
        start <= 1'b0;

        // wait out the last results, then a few quiet cycles
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
